// ----- rtl/core/binary_threshold_centroid_macros.svh -----
// Assertion macros shared by the binary threshold centroid RTL.
`ifndef BINARY_THRESHOLD_CENTROID_MACROS_SVH
`define BINARY_THRESHOLD_CENTROID_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/btc_pkg.sv -----
// Shared constants and types for the binary threshold centroid block.
package btc_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SIZE_W     = 11;
  localparam int TOTAL_W    = 21;
  localparam int CENTER_W   = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_DATA_W = 96;

  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [PIXEL_W-1:0] WHITE_LEVEL     = 8'd255;
  localparam logic [PIXEL_W-1:0] BLACK_LEVEL     = 8'd0;
  localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [SIZE_W-1:0]  WIDTH_RESET     = 11'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET    = 11'd480;

  // Per-item control carried from front to back
  typedef struct packed {
    logic white;  // pixel classified white
    logic last;   // last pixel of the frame, stats attached
  } btc_tag_t;

  typedef enum logic [1:0] {
    BK_PASS,
    BK_DIV,
    BK_OUT
  } btc_back_state_t;

endpackage

// ----- rtl/core/btc_front.sv -----
// Front end: config registers, thresholding, raster position and frame accumulators.
module btc_front import btc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic [PIXEL_W-1:0]    in_pixel,
  output logic                  in_ready,
  output logic                  push_valid,
  input  logic                  push_ready,
  output btc_tag_t              push_tag,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] push_white_cnt,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] push_black_cnt,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] push_wsx,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] push_wsy,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] push_bsx,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] push_bsy
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int QW    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int SUM_W = CNT_W + QW;
  localparam int WSZ_W = (SIZE_W > $clog2(MAX_WIDTH+1)) ? SIZE_W : $clog2(MAX_WIDTH+1);
  localparam int HSZ_W = (SIZE_W > $clog2(MAX_HEIGHT+1)) ? SIZE_W : $clog2(MAX_HEIGHT+1);

  logic [PIXEL_W-1:0] threshold;
  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] white_cnt, black_cnt;
  logic [SUM_W-1:0] wsx, wsy, bsx, bsy;

  logic [WSZ_W-1:0] w_eff;
  logic [HSZ_W-1:0] h_eff;
  logic             white, row_end, frame_end, accept;
  logic [CNT_W-1:0] white_cnt_next, black_cnt_next;
  logic [SUM_W-1:0] wsx_next, wsy_next, bsx_next, bsy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_THRESHOLD:    threshold    <= cfg_wdata[PIXEL_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_wdata[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Size zero acts as one, oversize saturates at the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WSZ_W'(1);
    end else if (WSZ_W'(frame_width) > WSZ_W'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HSZ_W'(1);
    end else if (HSZ_W'(frame_height) > HSZ_W'(MAX_HEIGHT)) begin
      h_eff = HSZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = HSZ_W'(frame_height);
    end
  end

  assign white     = in_pixel > threshold;
  assign row_end   = WSZ_W'(col) >= (w_eff - WSZ_W'(1));
  assign frame_end = row_end && (HSZ_W'(row) >= (h_eff - HSZ_W'(1)));
  assign accept    = in_valid && push_ready;

  // Accumulators including the current pixel
  always_comb begin
    white_cnt_next = white_cnt;
    black_cnt_next = black_cnt;
    wsx_next       = wsx;
    wsy_next       = wsy;
    bsx_next       = bsx;
    bsy_next       = bsy;
    if (white) begin
      white_cnt_next = white_cnt + CNT_W'(1);
      wsx_next       = wsx + SUM_W'(col);
      wsy_next       = wsy + SUM_W'(row);
    end else begin
      black_cnt_next = black_cnt + CNT_W'(1);
      bsx_next       = bsx + SUM_W'(col);
      bsy_next       = bsy + SUM_W'(row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      white_cnt <= '0;
      black_cnt <= '0;
      wsx       <= '0;
      wsy       <= '0;
      bsx       <= '0;
      bsy       <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col       <= '0;
        row       <= '0;
        white_cnt <= '0;
        black_cnt <= '0;
        wsx       <= '0;
        wsy       <= '0;
        bsx       <= '0;
        bsy       <= '0;
      end else begin
        if (row_end) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
        white_cnt <= white_cnt_next;
        black_cnt <= black_cnt_next;
        wsx       <= wsx_next;
        wsy       <= wsy_next;
        bsx       <= bsx_next;
        bsy       <= bsy_next;
      end
    end
  end

  assign in_ready       = push_ready;
  assign push_valid     = in_valid;
  assign push_tag.white = white;
  assign push_tag.last  = frame_end;
  assign push_white_cnt = white_cnt_next;
  assign push_black_cnt = black_cnt_next;
  assign push_wsx       = wsx_next;
  assign push_wsy       = wsy_next;
  assign push_bsx       = bsx_next;
  assign push_bsy       = bsy_next;

endmodule

// ----- rtl/core/btc_fifo.sv -----
// Small register queue between front and back end.
module btc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/btc_back.sv -----
// Back end: shared restoring divider for the four centroids and the output register.
`include "binary_threshold_centroid_macros.svh"
module btc_back import btc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  btc_tag_t              head_tag,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] head_white_cnt,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] head_black_cnt,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] head_wsx,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] head_wsy,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] head_bsx,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)
                + (($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0] head_bsy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_last,
  output logic [PIXEL_W-1:0]    out_binary_pixel,
  output logic [TOTAL_W-1:0]    out_white_total,
  output logic [TOTAL_W-1:0]    out_black_total,
  output logic [CENTER_W-1:0]   out_wcx,
  output logic [CENTER_W-1:0]   out_wcy,
  output logic [CENTER_W-1:0]   out_bcx,
  output logic [CENTER_W-1:0]   out_bcy,
  output logic                  out_white_empty,
  output logic                  out_black_empty
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int QW       = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W    = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int SUM_W    = CNT_W + QW;
  localparam int STEP_W   = $clog2(QW+1);
  localparam int NUM_DIV  = 4;
  localparam logic [1:0] DIV_LAST = 2'(NUM_DIV-1);

  btc_back_state_t state, state_next;

  // Divider operands, shifted down one slot per finished division
  logic [SUM_W-1:0]  num_q  [NUM_DIV];
  logic [CNT_W-1:0]  den_q  [NUM_DIV];
  logic [QW-1:0]     quot_q [NUM_DIV];
  logic [SUM_W-1:0]  rem, dvs, rem_next;
  logic [QW-1:0]     quo, quo_next;
  logic              take;
  logic [STEP_W-1:0] step;
  logic [1:0]        dcnt;
  logic [CNT_W-1:0]  white_cnt_hold, black_cnt_hold;
  logic              white_hold;

  logic out_free, pop, start_div, load_pass, load_stats, w_empty, b_empty;

  assign out_free = !out_valid || out_ready;
  assign pop      = pop_valid && pop_ready;

  always_comb begin
    state_next = state;
    case (state)
      BK_PASS: if (pop && head_tag.last) state_next = BK_DIV;
      BK_DIV:  if (step == '0 && dcnt == DIV_LAST) state_next = BK_OUT;
      BK_OUT:  if (out_free) state_next = BK_PASS;
      default: state_next = BK_PASS;
    endcase
  end

  always_comb begin
    pop_ready  = 1'b0;
    start_div  = 1'b0;
    load_pass  = 1'b0;
    load_stats = 1'b0;
    case (state)
      BK_PASS: begin
        pop_ready = out_free;
        start_div = pop && head_tag.last;
        load_pass = pop && !head_tag.last;
      end
      BK_OUT:  load_stats = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_PASS;
    end else begin
      state <= state_next;
    end
  end

  // One quotient bit per cycle; quotient fits QW bits since mean < max coordinate
  assign take     = rem >= dvs;
  assign rem_next = take ? rem - dvs : rem;
  assign quo_next = QW'({quo, take});

  always_ff @(posedge clk) begin
    if (start_div) begin
      num_q[0]       <= head_wsx;
      num_q[1]       <= head_wsy;
      num_q[2]       <= head_bsx;
      num_q[3]       <= head_bsy;
      den_q[0]       <= head_white_cnt;
      den_q[1]       <= head_white_cnt;
      den_q[2]       <= head_black_cnt;
      den_q[3]       <= head_black_cnt;
      white_cnt_hold <= head_white_cnt;
      black_cnt_hold <= head_black_cnt;
      white_hold     <= head_tag.white;
      rem            <= head_wsx;
      dvs            <= SUM_W'(head_white_cnt) << (QW-1);
      step           <= STEP_W'(QW-1);
      dcnt           <= '0;
    end else if (state == BK_DIV) begin
      quo <= quo_next;
      if (step == '0) begin
        for (int i = 0; i < NUM_DIV-1; i++) begin
          num_q[i]  <= num_q[i+1];
          den_q[i]  <= den_q[i+1];
          quot_q[i] <= quot_q[i+1];
        end
        quot_q[NUM_DIV-1] <= quo_next;
        rem  <= num_q[1];
        dvs  <= SUM_W'(den_q[1]) << (QW-1);
        step <= STEP_W'(QW-1);
        dcnt <= dcnt + 2'd1;
      end else begin
        rem  <= rem_next;
        dvs  <= dvs >> 1;
        step <= step - STEP_W'(1);
      end
    end
  end

  assign w_empty = white_cnt_hold == '0;
  assign b_empty = black_cnt_hold == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pass || load_stats) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pass) begin
      out_last         <= 1'b0;
      out_binary_pixel <= head_tag.white ? WHITE_LEVEL : BLACK_LEVEL;
      out_white_total  <= '0;
      out_black_total  <= '0;
      out_wcx          <= '0;
      out_wcy          <= '0;
      out_bcx          <= '0;
      out_bcy          <= '0;
      out_white_empty  <= 1'b0;
      out_black_empty  <= 1'b0;
    end else if (load_stats) begin
      out_last         <= 1'b1;
      out_binary_pixel <= white_hold ? WHITE_LEVEL : BLACK_LEVEL;
      out_white_total  <= TOTAL_W'(white_cnt_hold);
      out_black_total  <= TOTAL_W'(black_cnt_hold);
      out_wcx          <= w_empty ? '0 : CENTER_W'(quot_q[0]);
      out_wcy          <= w_empty ? '0 : CENTER_W'(quot_q[1]);
      out_bcx          <= b_empty ? '0 : CENTER_W'(quot_q[2]);
      out_bcy          <= b_empty ? '0 : CENTER_W'(quot_q[3]);
      out_white_empty  <= w_empty;
      out_black_empty  <= b_empty;
    end
  end

  `BTC_ASSERT_IMPL(a_no_pop_busy, state != BK_PASS, !pop, "queue popped while dividing")
  `BTC_ASSERT_NEXT(a_div_holds, (state == BK_DIV) && (step != '0), state == BK_DIV,
                   "divider left early")
  `BTC_ASSERT_IMPL(a_pass_zero, out_valid && !out_last,
                   (out_white_total == '0) && (out_black_total == '0) && !out_white_empty,
                   "stats on a non-final item")
  `BTC_ASSERT_IMPL(a_empty_center, out_valid && out_last && out_black_empty,
                   (out_bcx == '0) && (out_bcy == '0), "centroid set for empty class")

endmodule

// ----- rtl/core/binary_threshold_centroid.sv -----
// Top level: threshold with frame centroids. An ordinary pixel's result passes through a
// queue entry, then the output register. Frame end: the last pixel's result follows the
// four centroid divisions; the one shared divider yields one bit per cycle.
// Throughput: one pixel per cycle within a frame unless the output stalls; at frame end
// the 4-entry queue fills and the input stalls while dividing. Reset (rst, synchronous):
// threshold 128, 640x480, position and accumulators zero.
module binary_threshold_centroid import btc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // Config write port: index 0 threshold, 1 frame_width, 2 frame_height
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIXEL_W-1:0]    s_axis_tdata,   // [7:0] pixel_value
  // Result items; tlast is frame_done
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // binary_pixel[7:0], white_total[28:8],
                                                // black_total[49:29], white_center_x[59:50],
                                                // white_center_y[69:60],
                                                // black_center_x[79:70],
                                                // black_center_y[89:80], white_empty[90],
                                                // black_empty[91], zero [95:92]
  output logic                  m_axis_tlast
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int QW    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int SUM_W = CNT_W + QW;
  localparam int TAG_W = $bits(btc_tag_t);
  localparam int Q_W   = TAG_W + 2*CNT_W + 4*SUM_W;
  localparam int Q_DEPTH = 4;

  // Front to queue
  logic             push_valid, push_ready;
  btc_tag_t         push_tag;
  logic [CNT_W-1:0] push_wc, push_bc;
  logic [SUM_W-1:0] push_wsx, push_wsy, push_bsx, push_bsy;
  logic [Q_W-1:0]   push_data;

  // Queue to back
  logic             pop_valid, pop_ready;
  logic [Q_W-1:0]   pop_data;
  btc_tag_t         head_tag;
  logic [CNT_W-1:0] head_wc, head_bc;
  logic [SUM_W-1:0] head_wsx, head_wsy, head_bsx, head_bsy;

  // Result fields
  logic [PIXEL_W-1:0]  binary_pixel;
  logic [TOTAL_W-1:0]  white_total, black_total;
  logic [CENTER_W-1:0] white_center_x, white_center_y, black_center_x, black_center_y;
  logic                white_empty, black_empty;

  btc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (s_axis_tvalid),
    .in_pixel      (s_axis_tdata),
    .in_ready      (s_axis_tready),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_tag      (push_tag),
    .push_white_cnt(push_wc),
    .push_black_cnt(push_bc),
    .push_wsx      (push_wsx),
    .push_wsy      (push_wsy),
    .push_bsx      (push_bsx),
    .push_bsy      (push_bsy)
  );

  // Queue entry: stats on top, tag in the low bits
  assign push_data = {push_bsy, push_bsx, push_wsy, push_wsx, push_bc, push_wc, push_tag};

  btc_fifo #(
    .WIDTH(Q_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  assign {head_bsy, head_bsx, head_wsy, head_wsx, head_bc, head_wc, head_tag} = pop_data;

  btc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .head_tag        (head_tag),
    .head_white_cnt  (head_wc),
    .head_black_cnt  (head_bc),
    .head_wsx        (head_wsx),
    .head_wsy        (head_wsy),
    .head_bsx        (head_bsx),
    .head_bsy        (head_bsy),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_last        (m_axis_tlast),
    .out_binary_pixel(binary_pixel),
    .out_white_total (white_total),
    .out_black_total (black_total),
    .out_wcx         (white_center_x),
    .out_wcy         (white_center_y),
    .out_bcx         (black_center_x),
    .out_bcy         (black_center_y),
    .out_white_empty (white_empty),
    .out_black_empty (black_empty)
  );

  // Pack result fields, lowest first, zero-filled to whole bytes
  assign m_axis_tdata = OUT_DATA_W'({black_empty, white_empty,
                                     black_center_y, black_center_x,
                                     white_center_y, white_center_x,
                                     black_total, white_total, binary_pixel});

endmodule
